/* rtl/wait_die_record_lock_core_macros.svh */
// Assertion macros shared by the checker of the lock core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef WAIT_DIE_RECORD_LOCK_CORE_MACROS_SVH
`define WAIT_DIE_RECORD_LOCK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WDRL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lock core check failed");

// The consequent must hold in the cycle after the antecedent.
`define WDRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lock core check failed");

`endif

/* rtl/wdrl_pkg.sv */
`default_nettype none

package wdrl_pkg;

  // Width of the id and value fields on the ports.
  localparam int FieldW = 32;

  // Default sizes of the lock core.
  localparam int MaxReadersDef = 8;
  localparam int IdBitsDef     = 32;
  localparam int ValueBitsDef  = 32;

  typedef enum logic [2:0] {
    MODE_RLOCK   = 3'd0,
    MODE_RUNLOCK = 3'd1,
    MODE_WLOCK   = 3'd2,
    MODE_WUNLOCK = 3'd3,
    MODE_UPGRADE = 3'd4,
    MODE_WRITE   = 3'd5,
    MODE_PHANTOM = 3'd6,
    MODE_READ    = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_WAIT       = 3'd1,
    ST_DIE        = 3'd2,
    ST_NOT_HOLDER = 3'd3,
    ST_NOT_READER = 3'd4,
    ST_FULL       = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [FieldW-1:0] txn_id;
    logic [FieldW-1:0] new_value;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [FieldW-1:0] value_out;
    logic              phantom_out;
    logic [FieldW-1:0] oldest_holder;
  } rsp_t;

  // Flags that the slot scan hands to the decision logic.
  typedef struct packed {
    logic match;  // a valid slot holds the requesting id
    logic free;   // an unused slot exists
  } scan_flags_t;

endpackage

`default_nettype wire

/* rtl/wait_die_record_lock_core.sv */
`default_nettype none

// Lock manager for a single record under wait-die ordering, where a smaller
// transaction id is older. Each request on the input channel is a read lock,
// read unlock, write lock, write unlock, upgrade, write value, mark phantom
// or plain read, and yields exactly one result with a status, the record
// value, the phantom flag and the oldest current holder (zero when nobody
// holds the record). The reader slot ids sit in a memory with a single read
// port, which is swept one slot per cycle; the read data is then registered,
// the sweep is ended and the decision is committed once the output register
// can take it. The next request is accepted in the cycle the result appears,
// even while that result is still stalled by the consumer.
module wait_die_record_lock_core #(
  parameter int MAX_READERS = wdrl_pkg::MaxReadersDef,
  parameter int ID_BITS     = wdrl_pkg::IdBitsDef,
  parameter int VALUE_BITS  = wdrl_pkg::ValueBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire wdrl_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output wdrl_pkg::rsp_t      out_rsp_o
);

  // Ids and values wider than the port fields are cut to the field width.
  localparam int IdW   = (ID_BITS < wdrl_pkg::FieldW) ? ID_BITS : wdrl_pkg::FieldW;
  localparam int ValW  = (VALUE_BITS < wdrl_pkg::FieldW) ? VALUE_BITS : wdrl_pkg::FieldW;
  localparam int AddrW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int CntW  = $clog2(MAX_READERS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e                state_q;
  wdrl_pkg::mode_e       mode_q;
  logic [IdW-1:0]        id_q;
  logic [ValW-1:0]       nv_q;

  // Architectural lock state. The reader ids themselves live in the slot
  // memory; their valid bits are kept here in flops so reset clears them.
  logic [IdW-1:0]         writer_q, writer_d;
  logic [MAX_READERS-1:0] valid_q, valid_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [ValW-1:0]        value_q, value_d;
  logic                   phantom_q, phantom_d;

  logic                   out_valid_q;
  wdrl_pkg::rsp_t         out_rsp_q;

  logic                   in_accept;
  logic                   commit;
  wdrl_pkg::status_e      status_d;
  logic [IdW-1:0]         oldest_d;
  logic                   slot_we;

  // Scan interface.
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic [IdW-1:0]         rd_data;
  logic                   scan_done;
  wdrl_pkg::scan_flags_t  scan_flags;
  logic [IdW-1:0]         min_all;
  logic [IdW-1:0]         min_skip;
  logic [IdW-1:0]         min_rm;
  logic [IdW-1:0]         min_ins;
  logic [AddrW-1:0]       match_idx;
  logic [AddrW-1:0]       free_idx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // The decision is committed only once the output register can take it,
  // so a result waiting on the consumer is never overwritten.
  assign commit = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);

  wdrl_ram #(
    .Width (IdW),
    .Depth (MAX_READERS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (free_idx),
    .wdata_i (id_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  wdrl_scan #(
    .MaxReaders (MAX_READERS),
    .IdW        (IdW),
    .AddrW      (AddrW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .id_i        (id_q),
    .writer_i    (writer_q),
    .valid_i     (valid_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .done_o      (scan_done),
    .flags_o     (scan_flags),
    .min_all_o   (min_all),
    .min_skip_o  (min_skip),
    .min_rm_o    (min_rm),
    .min_ins_o   (min_ins),
    .match_idx_o (match_idx),
    .free_idx_o  (free_idx)
  );

  // Decision logic. The scan has already produced every oldest-holder value
  // that the request can need, both before and after its own update, so the
  // decision is a selection among them. Note that whenever a writer is held
  // the reader table is empty, since a read lock is only granted with no
  // writer and a write lock or upgrade only with no other reader.
  always_comb begin
    status_d  = wdrl_pkg::ST_GRANTED;
    writer_d  = writer_q;
    valid_d   = valid_q;
    count_d   = count_q;
    value_d   = value_q;
    phantom_d = phantom_q;
    oldest_d  = min_all;
    slot_we   = 1'b0;
    case (mode_q)
      wdrl_pkg::MODE_RLOCK: begin
        if (writer_q == '0) begin
          if (!scan_flags.free || (count_q >= CntW'(MAX_READERS))) begin
            status_d = wdrl_pkg::ST_FULL;
          end else begin
            slot_we            = commit;
            valid_d[free_idx]  = 1'b1;
            count_d            = count_q + CntW'(1);
            oldest_d           = min_ins;
          end
        end else if (writer_q > id_q) begin
          status_d = wdrl_pkg::ST_WAIT;
        end else begin
          status_d = wdrl_pkg::ST_DIE;
        end
      end
      wdrl_pkg::MODE_RUNLOCK: begin
        if (!scan_flags.match) begin
          status_d = wdrl_pkg::ST_NOT_READER;
        end else begin
          valid_d[match_idx] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CntW'(1);
          end
          oldest_d = min_rm;
        end
      end
      wdrl_pkg::MODE_WLOCK: begin
        if ((min_all != '0) && (min_all <= id_q)) begin
          status_d = wdrl_pkg::ST_DIE;
        end else if ((writer_q == '0) && (count_q == '0)) begin
          writer_d = id_q;
          oldest_d = id_q;
        end else begin
          status_d = wdrl_pkg::ST_WAIT;
        end
      end
      wdrl_pkg::MODE_WUNLOCK: begin
        if ((writer_q == '0) || (writer_q != id_q)) begin
          status_d = wdrl_pkg::ST_NOT_HOLDER;
        end else begin
          // With the writer gone and no readers, nobody holds the record.
          writer_d = '0;
          oldest_d = '0;
        end
      end
      wdrl_pkg::MODE_UPGRADE: begin
        if (!scan_flags.match) begin
          status_d = wdrl_pkg::ST_NOT_READER;
        end else if ((min_skip != '0) && (min_skip < id_q)) begin
          status_d = wdrl_pkg::ST_DIE;
        end else if ((writer_q == '0) && (count_q == CntW'(1))) begin
          valid_d[match_idx] = 1'b0;
          count_d            = '0;
          writer_d           = id_q;
          oldest_d           = id_q;
        end else begin
          status_d = wdrl_pkg::ST_WAIT;
        end
      end
      wdrl_pkg::MODE_WRITE: begin
        if ((writer_q == '0) || (writer_q != id_q)) begin
          status_d = wdrl_pkg::ST_NOT_HOLDER;
        end else begin
          value_d   = nv_q;
          phantom_d = 1'b0;
        end
      end
      wdrl_pkg::MODE_PHANTOM: begin
        if ((writer_q == '0) || (writer_q != id_q)) begin
          status_d = wdrl_pkg::ST_NOT_HOLDER;
        end else begin
          phantom_d = 1'b1;
        end
      end
      default: begin
        // A plain read is always granted and changes nothing.
        status_d = wdrl_pkg::ST_GRANTED;
      end
    endcase
  end

  // Sequencer: accept a request, let the scan sweep the slots, then commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= wdrl_pkg::MODE_READ;
      id_q        <= '0;
      nv_q        <= '0;
      writer_q    <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      value_q     <= '0;
      phantom_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            mode_q  <= wdrl_pkg::mode_e'(in_req_i.mode);
            id_q    <= in_req_i.txn_id[IdW-1:0];
            nv_q    <= in_req_i.new_value[ValW-1:0];
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            writer_q                <= writer_d;
            valid_q                 <= valid_d;
            count_q                 <= count_d;
            value_q                 <= value_d;
            phantom_q               <= phantom_d;
            out_valid_q             <= 1'b1;
            out_rsp_q.status        <= status_d;
            out_rsp_q.value_out     <= wdrl_pkg::FieldW'(value_d);
            out_rsp_q.phantom_out   <= phantom_d;
            out_rsp_q.oldest_holder <= wdrl_pkg::FieldW'(oldest_d);
            state_q                 <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

/* rtl/wdrl_ram.sv */
`default_nettype none

module wdrl_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/wdrl_scan.sv */
`default_nettype none

// Walks the reader slots in order, one memory read per cycle, and folds the
// holder ids into the running oldest values that the decision step needs.
module wdrl_scan #(
  parameter int MaxReaders = 8,
  parameter int IdW        = 32,
  parameter int AddrW      = 3
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [IdW-1:0]         id_i,
  input  wire logic [IdW-1:0]         writer_i,
  input  wire logic [MaxReaders-1:0]  valid_i,
  output logic                        rd_en_o,
  output logic      [AddrW-1:0]       rd_addr_o,
  input  wire logic [IdW-1:0]         rd_data_i,
  output logic                        done_o,
  output wdrl_pkg::scan_flags_t       flags_o,
  output logic      [IdW-1:0]         min_all_o,
  output logic      [IdW-1:0]         min_skip_o,
  output logic      [IdW-1:0]         min_rm_o,
  output logic      [IdW-1:0]         min_ins_o,
  output logic      [AddrW-1:0]       match_idx_o,
  output logic      [AddrW-1:0]       free_idx_o
);

  localparam logic [AddrW-1:0] LastIdx = AddrW'(MaxReaders - 1);

  logic             issue_q;
  logic [AddrW-1:0] addr_q;
  logic             pv_q;
  logic [AddrW-1:0] pidx_q;
  logic             plast_q;
  logic             done_q;

  logic [IdW-1:0]   all_q, all_d;
  logic [IdW-1:0]   skip_q, skip_d;
  logic [IdW-1:0]   rm_q, rm_d;
  logic [IdW-1:0]   ins_q, ins_d;
  logic             match_q, match_d;
  logic             free_q, free_d;
  logic [AddrW-1:0] match_idx_q, match_idx_d;
  logic [AddrW-1:0] free_idx_q, free_idx_d;

  logic             slot_v;
  logic             slot_hit;

  // An id of zero stands for no holder, so it is replaced by any reader.
  // The fold is order dependent and follows slot order exactly.
  function automatic logic [IdW-1:0] fold(input logic [IdW-1:0] best,
                                          input logic [IdW-1:0] r);
    fold = ((best == '0) || (r < best)) ? r : best;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      addr_q  <= '0;
      pv_q    <= 1'b0;
      pidx_q  <= '0;
      plast_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      pv_q    <= issue_q;
      pidx_q  <= addr_q;
      plast_q <= (addr_q == LastIdx);
      done_q  <= pv_q && plast_q;
      if (start_i) begin
        issue_q <= 1'b1;
        addr_q  <= '0;
      end else if (issue_q) begin
        if (addr_q == LastIdx) begin
          issue_q <= 1'b0;
        end else begin
          addr_q <= addr_q + AddrW'(1);
        end
      end
    end
  end

  always_comb begin
    slot_v      = valid_i[pidx_q];
    slot_hit    = slot_v && (rd_data_i == id_i);
    all_d       = all_q;
    skip_d      = skip_q;
    rm_d        = rm_q;
    ins_d       = ins_q;
    match_d     = match_q;
    free_d      = free_q;
    match_idx_d = match_idx_q;
    free_idx_d  = free_idx_q;
    if (slot_v) begin
      all_d = fold(all_q, rd_data_i);
      ins_d = fold(ins_q, rd_data_i);
      if (!slot_hit) begin
        skip_d = fold(skip_q, rd_data_i);
      end
      // The first matching slot is the one an unlock would free.
      if (slot_hit && !match_q) begin
        match_d     = 1'b1;
        match_idx_d = pidx_q;
      end else begin
        rm_d = fold(rm_q, rd_data_i);
      end
    end else if (!free_q) begin
      // The first free slot is where a read lock would place the id.
      free_d     = 1'b1;
      free_idx_d = pidx_q;
      ins_d      = fold(ins_q, id_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      all_q   <= writer_i;
      skip_q  <= writer_i;
      rm_q    <= writer_i;
      ins_q   <= writer_i;
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (pv_q) begin
      all_q       <= all_d;
      skip_q      <= skip_d;
      rm_q        <= rm_d;
      ins_q       <= ins_d;
      match_q     <= match_d;
      free_q      <= free_d;
      match_idx_q <= match_idx_d;
      free_idx_q  <= free_idx_d;
    end
  end

  assign rd_en_o       = issue_q;
  assign rd_addr_o     = addr_q;
  assign done_o        = done_q;
  assign flags_o.match = match_q;
  assign flags_o.free  = free_q;
  assign min_all_o     = all_q;
  assign min_skip_o    = skip_q;
  assign min_rm_o      = rm_q;
  assign min_ins_o     = ins_q;
  assign match_idx_o   = match_idx_q;
  assign free_idx_o    = free_idx_q;

endmodule

`default_nettype wire

/* rtl/wdrl_checker.sv */
`default_nettype none

`include "wait_die_record_lock_core_macros.svh"

module wdrl_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire wdrl_pkg::req_t in_req_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire wdrl_pkg::rsp_t out_rsp_o
);

  // A request keeps the core busy for at least the following cycle.
  `WDRL_ASSERT_NEXT(a_busy_after_request, in_valid_i && !in_stall_o, in_stall_o)

  // A fresh result coincides with the core being ready for a new request.
  `WDRL_ASSERT_SAME(a_ready_with_result, $rose(out_valid_o), !in_stall_o)

  // Only defined status codes are ever reported.
  `WDRL_ASSERT_SAME(a_status_code, out_valid_o,
                    out_rsp_o.status <= wdrl_pkg::ST_FULL)

  // A stalled result is held unchanged.
  `WDRL_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_rsp_o))

endmodule

bind wait_die_record_lock_core wdrl_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

/* test/wait_die_record_lock_checker.sv */
`default_nettype none

// Watches both channels of the lock core, predicts the result of every
// accepted request and compares each accepted result with the oldest
// prediction still waiting.
module wait_die_record_lock_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_stall_i,
  input  wire wdrl_pkg::req_t in_req_i,
  input  wire logic           out_valid_i,
  input  wire logic           out_stall_i,
  input  wire wdrl_pkg::rsp_t out_rsp_i,
  input  wire logic           end_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  checked_o
);
  import wdrl_pkg::*;

  localparam int Slots = MaxReadersDef;
  localparam int PrintCap = 100;

  // Predicted lock state.
  logic [FieldW-1:0] writer_id;
  logic [FieldW-1:0] reader_id [Slots];
  logic              reader_on [Slots];
  int unsigned       reader_total;
  logic [FieldW-1:0] rec_value;
  logic              rec_phantom;

  rsp_t expected_rsp [$];
  bit   end_checked;

  task automatic report_mismatch(input string what);
    if (errors_o < PrintCap) begin
      $display("lock core mismatch at result %0d: %s", checked_o, what);
    end
    errors_o++;
  endtask

  // Smallest id among the writer and the readers, optionally leaving out one id.
  function automatic logic [FieldW-1:0] oldest_id(input bit skip_en,
                                                  input logic [FieldW-1:0] skip_id);
    logic [FieldW-1:0] best;
    best = writer_id;
    for (int i = 0; i < Slots; i++) begin
      if (reader_on[i] && !(skip_en && reader_id[i] == skip_id)) begin
        if (best == '0 || reader_id[i] < best) begin
          best = reader_id[i];
        end
      end
    end
    return best;
  endfunction

  function automatic int slot_of(input logic [FieldW-1:0] id);
    for (int i = 0; i < Slots; i++) begin
      if (reader_on[i] && reader_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < Slots; i++) begin
      if (!reader_on[i]) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t predict_lock(input req_t r);
    mode_e             m;
    logic [FieldW-1:0] id;
    status_e           st;
    int                s;
    logic [FieldW-1:0] b;
    bit                is_writer;
    rsp_t              res;
    m = mode_e'(r.mode);
    id = r.txn_id;
    st = ST_GRANTED;
    is_writer = (writer_id != '0) && (writer_id == id);
    case (m)
      MODE_RLOCK: begin
        if (writer_id == '0) begin
          s = first_free_slot();
          if (s < 0 || reader_total >= Slots) begin
            st = ST_FULL;
          end else begin
            reader_id[s] = id;
            reader_on[s] = 1'b1;
            reader_total++;
          end
        end else if (writer_id > id) begin
          st = ST_WAIT;
        end else begin
          st = ST_DIE;
        end
      end
      MODE_RUNLOCK: begin
        s = slot_of(id);
        if (s < 0) begin
          st = ST_NOT_READER;
        end else begin
          reader_on[s] = 1'b0;
          if (reader_total > 0) reader_total--;
        end
      end
      MODE_WLOCK: begin
        b = oldest_id(1'b0, '0);
        if (b != '0 && b <= id) begin
          st = ST_DIE;
        end else if (writer_id == '0 && reader_total == 0) begin
          writer_id = id;
        end else begin
          st = ST_WAIT;
        end
      end
      MODE_WUNLOCK: begin
        if (!is_writer) st = ST_NOT_HOLDER;
        else writer_id = '0;
      end
      MODE_UPGRADE: begin
        s = slot_of(id);
        if (s < 0) begin
          st = ST_NOT_READER;
        end else begin
          b = oldest_id(1'b1, id);
          if (b != '0 && b < id) begin
            st = ST_DIE;
          end else if (writer_id == '0 && reader_total == 1) begin
            reader_on[s] = 1'b0;
            reader_total = 0;
            writer_id = id;
          end else begin
            st = ST_WAIT;
          end
        end
      end
      MODE_WRITE: begin
        if (!is_writer) begin
          st = ST_NOT_HOLDER;
        end else begin
          rec_value = r.new_value;
          rec_phantom = 1'b0;
        end
      end
      MODE_PHANTOM: begin
        if (!is_writer) st = ST_NOT_HOLDER;
        else rec_phantom = 1'b1;
      end
      default: begin
      end
    endcase
    res.status = st;
    res.value_out = rec_value;
    res.phantom_out = rec_phantom;
    res.oldest_holder = oldest_id(1'b0, '0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t want;
    if (!rst_ni) begin
      writer_id = '0;
      for (int i = 0; i < Slots; i++) begin
        reader_id[i] = '0;
        reader_on[i] = 1'b0;
      end
      reader_total = 0;
      rec_value = '0;
      rec_phantom = 1'b0;
      expected_rsp.delete();
      end_checked = 1'b0;
      errors_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      // A result never belongs to a request accepted at the same edge.
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("result arrived with no request waiting");
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp_i.status !== want.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_rsp_i.status, want.status));
          end
          if (out_rsp_i.value_out !== want.value_out) begin
            report_mismatch($sformatf("value got %h expected %h",
                                      out_rsp_i.value_out, want.value_out));
          end
          if (out_rsp_i.phantom_out !== want.phantom_out) begin
            report_mismatch($sformatf("phantom got %b expected %b",
                                      out_rsp_i.phantom_out, want.phantom_out));
          end
          if (out_rsp_i.oldest_holder !== want.oldest_holder) begin
            report_mismatch($sformatf("oldest holder got %h expected %h",
                                      out_rsp_i.oldest_holder, want.oldest_holder));
          end
        end
        checked_o++;
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        expected_rsp = {expected_rsp, predict_lock(in_req_i)};
      end
      if (end_i && !end_checked) begin
        end_checked = 1'b1;
        if (expected_rsp.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", expected_rsp.size()));
        end
      end
      pending_o = expected_rsp.size();
    end
  end

endmodule

`default_nettype wire

/* test/wait_die_record_lock_core_tb.sv */
`default_nettype none

// Testbench top for the wait-die record lock core. It resets the block once,
// sends a short directed list of requests and then random lock sessions under
// four mixes of sender idling and receiver stalling, and gives the verdict.
// All prediction and comparison lives in the checker instantiated beside the
// block; this module only makes stimulus and watches for a hung run.
module wait_die_record_lock_core_tb;
  import wdrl_pkg::*;

  localparam int PhaseReqs     = 275;
  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 40;
  localparam int PoolSize      = 5;
  localparam int NumLanes      = 3;
  localparam int RefreshEvery  = 80;
  localparam logic [FieldW-1:0] IdMax = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;
  logic run_over = 1'b0;

  // Idle mix of the current phase, in percent of cycles.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  // Each increment asks the receiver for one long hold-off.
  int hold_asks = 0;
  int hold_taken = 0;
  int hold_left = 0;

  int errors;
  int pending;
  int checked;
  int reqs_sent = 0;
  int quiet_cycles = 0;

  // Transaction ids that the random sessions draw from, so that they collide.
  logic [FieldW-1:0] id_pool [PoolSize];
  // Each lane holds the remaining requests of one open session.
  req_t session [NumLanes][$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  wait_die_record_lock_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  wait_die_record_lock_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .end_i       (run_over),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // The receiver stalls at random at the rate of the phase. When a hold-off
  // is asked for, it stalls for a long fixed stretch that it counts itself,
  // while the sender keeps offering requests, so the core fills up and has
  // to stall its request side.
  always @(posedge clk) begin : rx_drive
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asks) begin
      hold_taken <= hold_asks;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // The watchdog ends the run when neither channel has moved for too long.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t req_of(input mode_e m, input logic [FieldW-1:0] id,
                                  input logic [FieldW-1:0] val);
    req_t r;
    r.mode = m;
    r.txn_id = id;
    r.new_value = val;
    return r;
  endfunction

  // Offers one request and returns once it has been accepted. Valid stays
  // high afterwards, so back-to-back requests need no extra assignment; an
  // idle gap lowers it first.
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    reqs_sent++;
  endtask

  // Releases whatever the old pool ids may still hold, then draws new ids:
  // each either small and close together or spread over the full width.
  task automatic refresh_pool();
    logic [FieldW-1:0] id;
    foreach (id_pool[k]) begin
      send_req(req_of(MODE_RUNLOCK, id_pool[k], $urandom));
      send_req(req_of(MODE_RUNLOCK, id_pool[k], $urandom));
      send_req(req_of(MODE_WUNLOCK, id_pool[k], $urandom));
    end
    foreach (id_pool[k]) begin
      if ($urandom_range(1) == 0) begin
        id = $urandom_range(40, 2);
      end else begin
        id = $urandom;
        if (id < 2) id = 2;
      end
      id_pool[k] = id;
    end
  endtask

  // Appends one request to the open session of a lane.
  task automatic add_step(input int ln, input req_t r);
    session[ln] = {session[ln], r};
  endtask

  // Queues one well-formed session for a random pool id: a writer session,
  // a reader session, or a reader that upgrades and then writes.
  task automatic load_session(input int ln);
    logic [FieldW-1:0] id;
    id = id_pool[$urandom_range(PoolSize - 1)];
    case ($urandom_range(2))
      0: begin
        add_step(ln, req_of(MODE_WLOCK, id, $urandom));
        add_step(ln, req_of(MODE_WRITE, id, $urandom));
        if ($urandom_range(1) == 1) begin
          add_step(ln, req_of(MODE_PHANTOM, id, $urandom));
        end
        add_step(ln, req_of(MODE_WUNLOCK, id, $urandom));
      end
      1: begin
        add_step(ln, req_of(MODE_RLOCK, id, $urandom));
        add_step(ln, req_of(MODE_READ, id, $urandom));
        add_step(ln, req_of(MODE_RUNLOCK, id, $urandom));
      end
      default: begin
        add_step(ln, req_of(MODE_RLOCK, id, $urandom));
        add_step(ln, req_of(MODE_UPGRADE, id, $urandom));
        add_step(ln, req_of(MODE_WRITE, id, $urandom));
        add_step(ln, req_of(MODE_WUNLOCK, id, $urandom));
        // Frees the slot again when the upgrade did not go through.
        add_step(ln, req_of(MODE_RUNLOCK, id, $urandom));
      end
    endcase
  endtask

  // Interleaves several open sessions so that they contend for the record
  // and meet wait and die answers; a share of the requests is noise with a
  // random mode and sometimes an id outside the pool, reserved ids included.
  task automatic run_phase(input int n_reqs, input int tx_pct, input int rx_pct,
                           input bit with_hold);
    int stop;
    int next_refresh;
    int ln;
    logic [FieldW-1:0] nid;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    if (with_hold) hold_asks <= hold_asks + 1;
    stop = reqs_sent + n_reqs;
    next_refresh = reqs_sent + RefreshEvery;
    while (reqs_sent < stop) begin
      if (reqs_sent >= next_refresh) begin
        refresh_pool();
        next_refresh = reqs_sent + RefreshEvery;
      end
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(19))
          0: nid = $urandom_range(1);
          1, 2, 3: nid = $urandom;
          default: nid = id_pool[$urandom_range(PoolSize - 1)];
        endcase
        send_req(req_of(mode_e'($urandom_range(7)), nid, $urandom));
      end else begin
        ln = $urandom_range(NumLanes - 1);
        if (session[ln].size() == 0) load_session(ln);
        send_req(session[ln].pop_front());
      end
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A read right after reset sees the cleared record.
    send_req(req_of(MODE_READ, 2, 0));
    // With no writer, id zero must not count as the writer.
    send_req(req_of(MODE_WUNLOCK, 0, 0));
    send_req(req_of(MODE_WRITE, 0, 32'h1234_5678));
    // A duplicate reader takes a second slot and keeps an upgrade waiting.
    send_req(req_of(MODE_RLOCK, IdMax, 0));
    send_req(req_of(MODE_RLOCK, IdMax, 0));
    send_req(req_of(MODE_UPGRADE, IdMax, 0));
    send_req(req_of(MODE_RUNLOCK, IdMax, 0));
    send_req(req_of(MODE_UPGRADE, IdMax, 0));
    send_req(req_of(MODE_WRITE, IdMax, IdMax));
    send_req(req_of(MODE_PHANTOM, IdMax, 0));
    // Older requesters wait on the youngest possible writer; an equal id dies.
    send_req(req_of(MODE_RLOCK, 2, 0));
    send_req(req_of(MODE_WLOCK, 3, 0));
    send_req(req_of(MODE_RLOCK, IdMax, 0));
    // Writing zero clears the phantom flag.
    send_req(req_of(MODE_WRITE, IdMax, 0));
    send_req(req_of(MODE_WUNLOCK, IdMax, 0));
    send_req(req_of(MODE_RUNLOCK, 5, 0));
    // Fill every reader slot, then overflow the table.
    for (int k = 0; k < MaxReadersDef; k++) begin
      send_req(req_of(MODE_RLOCK, 2 + k, 0));
    end
    send_req(req_of(MODE_RLOCK, 20, 0));
    // An upgrade with older readers around dies, as does a write lock
    // from the oldest reader itself.
    send_req(req_of(MODE_UPGRADE, 9, 0));
    send_req(req_of(MODE_WLOCK, 2, 0));
    // Empty the table again before the random sessions start.
    for (int k = 0; k < MaxReadersDef; k++) begin
      send_req(req_of(MODE_RUNLOCK, 2 + k, 0));
    end
    foreach (id_pool[k]) id_pool[k] = 2 + k;
    refresh_pool();

    // Random part: free running, sender gaps, receiver stalls, then both.
    run_phase(PhaseReqs, 0, 0, 1'b1);
    run_phase(PhaseReqs, 63, 0, 1'b0);
    run_phase(PhaseReqs, 0, 63, 1'b0);
    run_phase(PhaseReqs, 37, 37, 1'b1);
    in_valid <= 1'b0;

    // Drain: every result must arrive; the watchdog catches a hang.
    while (pending != 0 || hold_left != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    run_over <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run covered %0d requests: directed corner cases, then contending lock",
             reqs_sent);
    $display("sessions under four idle and stall mixes with two long hold-offs; %0d results.",
             checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
